/* rtl/tcp_congestion_window_update_assert.svh */
// Assertion macros for the congestion window RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef TCP_CONGESTION_WINDOW_UPDATE_ASSERT_SVH
`define TCP_CONGESTION_WINDOW_UPDATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TCPCW_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TCPCW_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCPCW_ASSERT(name, clk, rst, prop, msg)
`define TCPCW_ASSERT_NR(name, clk, prop, msg)
`endif
`endif

/* rtl/tcpcw_pkg.sv */
// Package for the congestion window block: item types, phase codes,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
package tcpcw_pkg;

  localparam int DUPACK_LIMIT_DEF = 3;
  localparam int WINDOW_BITS_DEF  = 16;

  localparam logic [1:0] PH_OPEN     = 2'd0;
  localparam logic [1:0] PH_DISORDER = 2'd1;
  localparam logic [1:0] PH_RECOVERY = 2'd2;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INIT_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INIT_UNACKED   = 2'd1;

  localparam logic [15:0] THRESHOLD_RESET = 16'd64;
  localparam logic [31:0] UNACKED_RESET   = 32'd0;

  typedef struct packed {
    logic [31:0] ack_number;
    logic [31:0] next_send_seq;
  } ack_item_t;

  typedef struct packed {
    logic        need_resend;
    logic        ack_error;
    logic [15:0] window_size;
    logic [15:0] slow_start_threshold;
    logic [1:0]  window_phase;
    logic [31:0] oldest_unacked;
  } result_item_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] reg_index;
    logic [31:0]               reg_data;
  } cfg_item_t;

  // Connection state apart from the window, whose width is a parameter.
  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  dup_count;
    logic [15:0] threshold;
    logic [31:0] unacked_seq;
    logic [31:0] recovery_mark;
    logic [15:0] avoid_count;
  } conn_state_t;

endpackage

/* rtl/tcpcw_chan_if.sv */
// Valid/ready channel carrying one item of a given payload type.
// No dependencies.
`timescale 1ns / 1ps
interface tcpcw_chan_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/tcpcw_in_stage.sv */
// Input register for ACK items.
// Depends on tcpcw_pkg and tcpcw_chan_if.
`timescale 1ns / 1ps
module tcpcw_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  tcpcw_chan_if.sink            ack,
  input  logic                  advance,
  output logic                  valid,
  output tcpcw_pkg::ack_item_t  item
);
  assign ack.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ack.ready) begin
      valid <= ack.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ack.valid && ack.ready) begin
      item <= ack.data;
    end
  end
endmodule

/* rtl/tcpcw_update.sv */
// Next-state and result logic for one ACK against the current state.
// Depends on tcpcw_pkg.
`timescale 1ns / 1ps
module tcpcw_update #(
  parameter int DUPACK_LIMIT = tcpcw_pkg::DUPACK_LIMIT_DEF,
  parameter int WINDOW_BITS  = tcpcw_pkg::WINDOW_BITS_DEF
) (
  input  tcpcw_pkg::conn_state_t  cur,
  input  logic [WINDOW_BITS-1:0]  window_cur,
  input  tcpcw_pkg::ack_item_t    item,
  output tcpcw_pkg::conn_state_t  nxt,
  output logic [WINDOW_BITS-1:0]  window_nxt,
  output tcpcw_pkg::result_item_t res
);
  import tcpcw_pkg::*;

  localparam int CW = (WINDOW_BITS > 16) ? WINDOW_BITS : 16;

  logic                   dup;
  logic                   ahead;
  logic                   err;
  logic                   resend;
  logic                   grow;
  logic [31:0]            diff;
  logic [31:0]            mark_diff;
  logic [WINDOW_BITS-1:0] w;

  assign diff      = item.ack_number - cur.unacked_seq;
  assign mark_diff = cur.recovery_mark - item.ack_number;
  assign dup       = (diff == 32'd0);
  assign ahead     = (diff != 32'd0) && !diff[31];
  assign err       = !dup && !ahead;

  always_comb begin
    nxt    = cur;
    w      = window_cur;
    resend = 1'b0;
    grow   = 1'b0;
    if (!err) begin
      case (cur.phase)
        PH_OPEN: begin
          if (dup) begin
            nxt.dup_count = 8'd1;
            nxt.phase     = PH_DISORDER;
          end else begin
            nxt.unacked_seq = item.ack_number;
            nxt.dup_count   = 8'd0;
          end
          grow = 1'b1;
        end
        PH_DISORDER: begin
          if (dup) begin
            if (cur.dup_count != 8'hFF) begin
              nxt.dup_count = cur.dup_count + 8'd1;
            end
            if (nxt.dup_count >= 8'(DUPACK_LIMIT)) begin
              nxt.phase         = PH_RECOVERY;
              nxt.recovery_mark = item.next_send_seq;
              w                 = window_cur >> 1;
              if (w == '0) begin
                w = WINDOW_BITS'(1);
              end
              nxt.threshold = (CW'(w) > CW'(16'hFFFF)) ? 16'hFFFF : 16'(w);
              resend        = 1'b1;
            end
          end else begin
            nxt.unacked_seq = item.ack_number;
            nxt.dup_count   = 8'd0;
            nxt.phase       = PH_OPEN;
          end
          grow = 1'b1;
        end
        default: begin
          if (dup) begin
            if (cur.dup_count != 8'hFF) begin
              nxt.dup_count = cur.dup_count + 8'd1;
            end
          end else begin
            nxt.unacked_seq = item.ack_number;
            nxt.dup_count   = 8'd0;
            if (mark_diff != 32'd0 && !mark_diff[31]) begin
              resend = 1'b1;
            end else begin
              nxt.phase = PH_OPEN;
            end
          end
        end
      endcase
    end

    // slow start below the threshold, one segment per window of ACKs above
    if (grow) begin
      if (CW'(w) < CW'(nxt.threshold)) begin
        nxt.avoid_count = 16'd0;
        if (w != '1) begin
          w = w + 1'b1;
        end
      end else begin
        if (nxt.avoid_count != 16'hFFFF) begin
          nxt.avoid_count = nxt.avoid_count + 16'd1;
        end
        if (CW'(nxt.avoid_count) >= CW'(w)) begin
          nxt.avoid_count = 16'd0;
          if (w != '1) begin
            w = w + 1'b1;
          end
        end
      end
    end
  end

  assign window_nxt = w;

  assign res.need_resend          = resend;
  assign res.ack_error            = err;
  assign res.window_size          = 16'(w);
  assign res.slow_start_threshold = nxt.threshold;
  assign res.window_phase         = nxt.phase;
  assign res.oldest_unacked       = nxt.unacked_seq;
endmodule

/* rtl/tcp_congestion_window_update.sv */
// Top level of the congestion window block: state, result register, config.
// Depends on tcpcw_pkg, tcpcw_chan_if, tcpcw_in_stage, tcpcw_update.
//
// channel  role    payload
// ack      sink    ack_number, next_send_seq
// result   source  need_resend, ack_error, window_size, slow_start_threshold,
//                  window_phase, oldest_unacked
// cfg      sink    reg_index, reg_data (0 initial threshold, 1 initial unacked)
//
// One ACK per cycle while result is not stalled; each result is registered.
// The input register feeds the update logic, which writes the state and the
// result register in the same cycle, so each ACK sees the state its
// predecessor left. A stalled result holds the pipe; cfg is always ready.
// Reset: window 1, threshold 64, unacked 0, phase open, counts zero.
`timescale 1ns / 1ps
`include "tcp_congestion_window_update_assert.svh"
module tcp_congestion_window_update #(
  parameter int DUPACK_LIMIT = tcpcw_pkg::DUPACK_LIMIT_DEF,
  parameter int WINDOW_BITS  = tcpcw_pkg::WINDOW_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tcpcw_chan_if.sink   ack,
  tcpcw_chan_if.source result,
  tcpcw_chan_if.sink   cfg
);
  import tcpcw_pkg::*;

  logic                   advance;
  logic                   fire;
  logic                   s1_valid;
  ack_item_t              s1_item;
  conn_state_t            state;
  conn_state_t            state_next;
  logic [WINDOW_BITS-1:0] window;
  logic [WINDOW_BITS-1:0] window_next;
  result_item_t           upd_res;
  result_item_t           res_q;
  logic                   res_valid;
  cfg_item_t              cfg_item;

  assign advance = !res_valid || result.ready;
  assign fire    = s1_valid && advance;

  tcpcw_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .ack     (ack),
    .advance (advance),
    .valid   (s1_valid),
    .item    (s1_item)
  );

  tcpcw_update #(
    .DUPACK_LIMIT (DUPACK_LIMIT),
    .WINDOW_BITS  (WINDOW_BITS)
  ) u_upd (
    .cur        (state),
    .window_cur (window),
    .item       (s1_item),
    .nxt        (state_next),
    .window_nxt (window_next),
    .res        (upd_res)
  );

  assign cfg.ready = 1'b1;
  assign cfg_item  = cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_OPEN;
      state.dup_count     <= 8'd0;
      state.threshold     <= THRESHOLD_RESET;
      state.unacked_seq   <= UNACKED_RESET;
      state.recovery_mark <= 32'd0;
      state.avoid_count   <= 16'd0;
      window              <= WINDOW_BITS'(1);
    end else begin
      if (fire) begin
        state  <= state_next;
        window <= window_next;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_item.reg_index)
          REG_INIT_THRESHOLD: state.threshold   <= cfg_item.reg_data[15:0];
          REG_INIT_UNACKED:   state.unacked_seq <= cfg_item.reg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= upd_res;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_q;

  `TCPCW_ASSERT(a_window_nonzero, clk, rst, window != '0, "window reached zero")
  `TCPCW_ASSERT(a_err_keeps_state, clk, rst,
    fire && upd_res.ack_error |=> $stable(window) && $stable(state.phase),
    "rejected ACK changed window state")
  `TCPCW_ASSERT(a_resend_in_recovery, clk, rst,
    res_valid && res_q.need_resend |-> res_q.window_phase == PH_RECOVERY,
    "resend outside recovery")
  `TCPCW_ASSERT(a_resend_not_err, clk, rst,
    res_valid |-> !(res_q.need_resend && res_q.ack_error),
    "resend on rejected ACK")
  `TCPCW_ASSERT(a_fire_gives_result, clk, rst, fire |=> res_valid,
    "processed ACK produced no result")
endmodule
